>>> hdl/png_chunk_deframer_unit_defines.svh
// ----------------------------------------------------------------------------
// png_chunk_deframer_unit_defines
// Assertion macros shared by the deframer RTL. Every macro samples on clk and
// is switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PNG_CHUNK_DEFRAMER_UNIT_DEFINES_SVH
`define PNG_CHUNK_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication
`define PCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// Types, constants and helper functions for the PNG chunk deframer: field
// phases, result and status codes, the chunk name table and the CRC-32 step.
// ----------------------------------------------------------------------------
package pcd_pkg;

  // bytes in each fixed-size chunk field (length, name, crc)
  localparam int unsigned FIELD_BYTES = 4;

  // reflected CRC-32 polynomial and the initial / final xor value
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // name table sizes and the number of entries searched
  localparam int unsigned PNG_TABLE_SIZE  = 18;
  localparam int unsigned APNG_TABLE_SIZE = 3;
  localparam int unsigned PNG_NAME_COUNT  = 18;
  localparam int unsigned APNG_NAME_COUNT = 3;

  localparam logic [31:0] PNG_NAMES [PNG_TABLE_SIZE] = '{
    32'h4948_4452, 32'h504C_5445, 32'h4944_4154, 32'h4945_4E44, 32'h7452_4E53,
    32'h6348_524D, 32'h6741_4D41, 32'h6943_4350, 32'h7342_4954, 32'h7352_4742,
    32'h7445_5874, 32'h7A54_5874, 32'h6954_5874, 32'h624B_4744, 32'h6849_5354,
    32'h7048_5973, 32'h7350_4C54, 32'h7449_4D45
  };

  localparam logic [31:0] APNG_NAMES [APNG_TABLE_SIZE] = '{
    32'h6163_544C, 32'h6663_544C, 32'h6664_4154
  };

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_NAME = 2'd1,
    PH_DATA = 2'd2,
    PH_CRC  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_CHUNK   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SIZE = 2'd1,
    ST_NAME = 2'd2,
    ST_CRC  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    NC_INVALID = 2'd0,
    NC_PNG     = 2'd1,
    NC_APNG    = 2'd2
  } name_class_t;

  // one result word as produced by the parser
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [31:0] chunk_length;
    logic [31:0] chunk_name;
    status_t     status;
    logic [31:0] error_offset;
    logic        apng_seen;
  } result_t;

  // parser status seen by the top level
  typedef struct packed {
    logic   error_hold;
    logic   apng_flag;
  } core_stat_t;

  // one byte of the reflected CRC-32 update
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    c = c_in ^ {24'h00_0000, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // look the name up in the png table first, then the apng table
  function automatic name_class_t classify(input logic [31:0] nm);
    logic png_hit;
    logic apng_hit;
    png_hit  = 1'b0;
    apng_hit = 1'b0;
    for (int i = 0; i < PNG_TABLE_SIZE; i++) begin
      if (i < PNG_NAME_COUNT && PNG_NAMES[i] == nm) png_hit = 1'b1;
    end
    for (int j = 0; j < APNG_TABLE_SIZE; j++) begin
      if (j < APNG_NAME_COUNT && APNG_NAMES[j] == nm) apng_hit = 1'b1;
    end
    if (png_hit) return NC_PNG;
    if (apng_hit) return NC_APNG;
    return NC_INVALID;
  endfunction

endpackage

>>> hdl/pcd_in_if.sv
// ----------------------------------------------------------------------------
// pcd_in_if
// Byte stream channel into the deframer: one stream byte and the
// buffer-end mark per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

>>> hdl/pcd_out_if.sv
// ----------------------------------------------------------------------------
// pcd_out_if
// Result channel out of the deframer: payload bytes, chunk verdicts and
// parse errors, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [31:0] chunk_length;
  logic [31:0] chunk_name;
  logic [1:0]  status_code;
  logic [31:0] error_offset;
  logic        apng_seen;

  modport source (output valid, output result_kind, output payload_byte,
                  output chunk_length, output chunk_name, output status_code,
                  output error_offset, output apng_seen, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input chunk_length, input chunk_name, input status_code,
                  input error_offset, input apng_seen, output ready);
endinterface

>>> hdl/pcd_parse_core.sv
// ----------------------------------------------------------------------------
// pcd_parse_core
// Chunk field tracker. Holds the phase, byte counts, field registers and the
// running CRC, and forms at most one result word for each accepted byte.
// ----------------------------------------------------------------------------
module pcd_parse_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                buffer_end,
  output logic                res_valid,
  output pcd_pkg::result_t    res,
  output pcd_pkg::core_stat_t stat
);
  import pcd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] name_r, name_nxt;
  logic [31:0] scrc_r, scrc_nxt;
  logic [31:0] crc_r, crc_nxt;
  name_class_t class_r, class_nxt;
  logic [31:0] cstart_r, cstart_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic        apng_r, apng_nxt;
  logic        hold_r, hold_nxt;

  logic        chunk_start;
  logic [31:0] len_b, name_b, scrc_b, crc_b, cstart_b;
  name_class_t class_b;
  logic [31:0] cnt_inc;
  logic [31:0] off_inc;
  logic [31:0] name_sh;
  logic [31:0] crc_upd;
  logic        field_end;
  logic        done;

  // field registers start afresh on the first length byte of a chunk
  assign chunk_start = (phase_r == PH_LEN) && (cnt_r == '0);
  assign len_b       = chunk_start ? '0 : len_r;
  assign name_b      = chunk_start ? '0 : name_r;
  assign scrc_b      = chunk_start ? '0 : scrc_r;
  assign crc_b       = chunk_start ? CRC_INIT : crc_r;
  assign class_b     = chunk_start ? NC_INVALID : class_r;
  assign cstart_b    = chunk_start ? offset_r : cstart_r;

  assign cnt_inc = cnt_r + 32'd1;
  assign off_inc = offset_r + 32'd1;
  assign name_sh = {name_b[23:0], data_byte};
  assign crc_upd = crc_byte(crc_b, data_byte);

  // last byte of the current field
  assign field_end = (phase_r == PH_DATA) ? (cnt_inc == len_b)
                                          : (cnt_inc == 32'(FIELD_BYTES));
  assign done      = (phase_r == PH_CRC) && field_end;

  // next phase and byte count
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    if (accept) begin
      if (hold_r) begin
        if (buffer_end) begin
          phase_nxt = PH_LEN;
          cnt_nxt   = '0;
        end
      end else if (buffer_end && !done) begin
        phase_nxt = PH_LEN;
        cnt_nxt   = '0;
      end else if (field_end) begin
        cnt_nxt = '0;
        unique case (phase_r)
          PH_LEN:  phase_nxt = PH_NAME;
          PH_NAME: phase_nxt = (len_b == '0) ? PH_CRC : PH_DATA;
          PH_DATA: phase_nxt = PH_CRC;
          PH_CRC:  phase_nxt = PH_LEN;
          default: phase_nxt = PH_LEN;
        endcase
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  // field registers, crc, flags and the result word
  always_comb begin
    len_nxt    = len_r;
    name_nxt   = name_r;
    scrc_nxt   = scrc_r;
    crc_nxt    = crc_r;
    class_nxt  = class_r;
    cstart_nxt = cstart_r;
    offset_nxt = offset_r;
    apng_nxt   = apng_r;
    hold_nxt   = hold_r;

    res_valid        = 1'b0;
    res.kind         = KIND_PAYLOAD;
    res.payload_byte = '0;
    res.chunk_length = len_r;
    res.chunk_name   = name_r;
    res.status       = ST_OK;
    res.error_offset = cstart_r;
    res.apng_seen    = apng_r;

    if (accept && hold_r) begin
      // ignoring bytes until the buffer-end mark
      if (buffer_end) begin
        offset_nxt = '0;
        hold_nxt   = 1'b0;
      end
    end else if (accept) begin
      len_nxt    = len_b;
      name_nxt   = name_b;
      scrc_nxt   = scrc_b;
      crc_nxt    = crc_b;
      class_nxt  = class_b;
      cstart_nxt = cstart_b;
      offset_nxt = off_inc;

      unique case (phase_r)
        PH_LEN:  len_nxt = {len_b[23:0], data_byte};
        PH_NAME: begin
          name_nxt = name_sh;
          crc_nxt  = crc_upd;
          if (field_end) class_nxt = classify(name_sh);
        end
        PH_DATA: crc_nxt = crc_upd;
        PH_CRC:  scrc_nxt = {scrc_b[23:0], data_byte};
        default: len_nxt = len_b;
      endcase

      res.chunk_length = len_nxt;
      res.chunk_name   = name_nxt;
      res.error_offset = cstart_nxt;

      if (buffer_end && !done) begin
        // chunk cut short by the buffer end
        res_valid  = 1'b1;
        res.kind   = KIND_ERROR;
        res.status = ST_SIZE;
        offset_nxt = '0;
      end else if (!done) begin
        if (phase_r == PH_DATA) begin
          res_valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = data_byte;
        end
      end else begin
        // chunk complete: name check, then crc check
        res_valid = 1'b1;
        if (class_b == NC_INVALID) begin
          res.kind   = KIND_ERROR;
          res.status = ST_NAME;
          hold_nxt   = !buffer_end;
        end else begin
          if (class_b == NC_APNG) apng_nxt = 1'b1;
          if ((crc_b ^ CRC_INIT) != scrc_nxt) begin
            res.kind         = KIND_ERROR;
            res.status       = ST_CRC;
            res.error_offset = off_inc;
            hold_nxt         = !buffer_end;
          end else begin
            res.kind = KIND_CHUNK;
          end
        end
        if (buffer_end) offset_nxt = '0;
      end
      res.apng_seen = apng_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEN;
      cnt_r    <= '0;
      offset_r <= '0;
      apng_r   <= 1'b0;
      hold_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      offset_r <= offset_nxt;
      apng_r   <= apng_nxt;
      hold_r   <= hold_nxt;
    end
  end

  // field registers, reloaded at every chunk start
  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    name_r   <= name_nxt;
    scrc_r   <= scrc_nxt;
    crc_r    <= crc_nxt;
    class_r  <= class_nxt;
    cstart_r <= cstart_nxt;
  end

  assign stat.error_hold = hold_r;
  assign stat.apng_flag  = apng_r;

endmodule

>>> hdl/pcd_result_reg.sv
// ----------------------------------------------------------------------------
// pcd_result_reg
// Output register of the deframer. Holds one result word and frees its slot
// in the cycle the sink takes it, so a new byte can enter at the same edge.
// ----------------------------------------------------------------------------
module pcd_result_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic             res_valid,
  input  pcd_pkg::result_t res,
  output logic             space,
  pcd_out_if.source        out_ch
);
  import pcd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  // slot is free when empty or being drained
  assign space = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = res_valid;
      if (res_valid) res_nxt = res;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // drive the channel
  assign out_ch.valid        = valid_r;
  assign out_ch.result_kind  = res_r.kind;
  assign out_ch.payload_byte = res_r.payload_byte;
  assign out_ch.chunk_length = res_r.chunk_length;
  assign out_ch.chunk_name   = res_r.chunk_name;
  assign out_ch.status_code  = res_r.status;
  assign out_ch.error_offset = res_r.error_offset;
  assign out_ch.apng_seen    = res_r.apng_seen;

endmodule

>>> hdl/png_chunk_deframer_unit.sv
// ----------------------------------------------------------------------------
// png_chunk_deframer_unit
// Timing: a result word is valid in the cycle after the byte that causes it.
// Throughput: one byte per cycle while the output slot is free; the byte-wide CRC-32 step and the phase
//   logic between the parser registers and the output register set it.
// Reset: synchronous, active low; clears phase, counts, offset, error hold,
//   the APNG flag and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
`include "png_chunk_deframer_unit_defines.svh"

module png_chunk_deframer_unit (
  input  logic      clk,
  input  logic      rst_n,
  pcd_in_if.sink    in_ch,
  pcd_out_if.source out_ch
);
  import pcd_pkg::*;

  logic       accept;
  logic       space;
  logic       res_valid;
  result_t    res;
  core_stat_t stat;

  // a byte enters whenever the output slot is free
  assign in_ch.ready = space;
  assign accept      = in_ch.valid && space;

  pcd_parse_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_ch.data_byte),
    .buffer_end (in_ch.buffer_end),
    .res_valid  (res_valid),
    .res        (res),
    .stat       (stat)
  );

  pcd_result_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .out_ch    (out_ch)
  );

  // checks
  `PCD_ASSERT_NOW(a_no_overwrite, out_ch.valid && !out_ch.ready, !in_ch.ready, "stalled word would be overwritten")
  `PCD_ASSERT_NOW(a_status_kind, out_ch.valid, (out_ch.result_kind == KIND_ERROR) == (out_ch.status_code != ST_OK), "status code disagrees with result kind")
  `PCD_ASSERT_NEXT(a_apng_sticky, stat.apng_flag, stat.apng_flag, "apng flag cleared")
  `PCD_ASSERT_NEXT(a_hold_silent, accept && stat.error_hold, !out_ch.valid, "result while ignoring after an error")

endmodule
